### src/sdinit_pkg.sv
// ----------------------------------------------------------------------------
// sdinit_pkg: shared types and constants for the SD card init sequencer
// Phase encoding, command numbers, outcome codes, register map, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sdinit_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CMD0   = 3'd1,
    PH_CMD8   = 3'd2,
    PH_CMD55  = 3'd3,
    PH_ACMD41 = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // command numbers
  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_SEND_IF     = 6'd8;
  localparam logic [5:0] CMD_APP         = 6'd55;
  localparam logic [5:0] ACMD_SD_OP_COND = 6'd41;

  // outcome codes
  localparam logic [2:0] OUT_RUNNING     = 3'd0;
  localparam logic [2:0] OUT_READY       = 3'd1;
  localparam logic [2:0] OUT_CHECK_FAIL  = 3'd2;
  localparam logic [2:0] OUT_CMD55_FAIL  = 3'd3;
  localparam logic [2:0] OUT_ACMD41_FAIL = 3'd4;
  localparam logic [2:0] OUT_TIMEOUT     = 3'd5;

  // input opcodes
  localparam logic OP_START    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // register map
  localparam int          CFG_IDX_W         = 3;
  localparam logic [2:0]  CFG_MAX_ATTEMPTS  = 3'd0;
  localparam logic [2:0]  CFG_HCS_DROP      = 3'd1;
  localparam logic [2:0]  CFG_START_ARG     = 3'd2;
  localparam logic [2:0]  CFG_FEEDBACK_MASK = 3'd3;
  localparam logic [2:0]  CFG_FALLBACK_ARG  = 3'd4;
  localparam logic [2:0]  CFG_CHECK_PATTERN = 3'd5;

  // register reset values
  localparam logic [6:0]  RST_MAX_ATTEMPTS  = 7'd100;
  localparam logic [6:0]  RST_HCS_DROP      = 7'd50;
  localparam logic [31:0] RST_START_ARG     = 32'h4000_0000;
  localparam logic [31:0] RST_FEEDBACK_MASK = 32'h40FF_8000;
  localparam logic [31:0] RST_FALLBACK_ARG  = 32'h00FF_8000;
  localparam logic [11:0] RST_CHECK_PATTERN = 12'h1AA;

  // status / OCR fields
  localparam logic [15:0] ST_RECEIVED = 16'h0011;  // end bit or crc bit
  localparam int          OCR_READY_BIT = 31;
  localparam int          OCR_HCS_BIT   = 30;
  localparam logic [31:0] OCR_WINDOW    = 32'h00FF_FFFF;

  typedef struct packed {
    logic [6:0]  max_attempts;
    logic [6:0]  hcs_drop_attempt;
    logic [31:0] start_argument;
    logic [31:0] feedback_mask;
    logic [31:0] fallback_argument;
    logic [11:0] check_pattern;
  } cfg_t;

  typedef struct packed {
    logic        command_valid;
    logic [5:0]  command_index;
    logic [31:0] command_argument;
    logic        expects_response;
    logic [2:0]  outcome;
    logic [6:0]  attempt_count;
    logic [31:0] card_ocr;
    logic [15:0] last_status;
    logic        high_capacity;
    logic [31:0] argument_in_use;
  } result_t;

endpackage

`default_nettype wire

### src/sd_card_init_sequencer_core.sv
// ----------------------------------------------------------------------------
// sd_card_init_sequencer_core: SD card bring-up command sequencer
// Usage:
//   Input channel (in_valid/in_stall, opcode, status_flags, response_word):
//   a start request begins the sequence with CMD0; each response request
//   yields the next command (CMD8, CMD55, ACMD41) or a final outcome.
//   Output channel (out_valid/out_stall): one result per start request and
//   per response taken while the sequence runs; responses taken while idle
//   or finished produce nothing.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   write only while no request is in flight.
// Timing: a request is registered in the input stage, judged there by the
//   sequencer and its result is registered in the result stage. One request
//   per cycle is sustained while out_stall holds no result; the state update
//   of the sequencer is registered together with the result.
// Reset (rst, synchronous): sequence idle, registers to their defaults, both
//   pipeline stages empty.
// Stall: while out_stall holds a result, the input stage holds its request
//   and in_stall rises; a held response that produces no result still drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_card_init_sequencer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             opcode,
  input  wire logic [15:0]                      status_flags,
  input  wire logic [31:0]                      response_word,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  command_valid,
  output logic [5:0]                            command_index,
  output logic [31:0]                           command_argument,
  output logic                                  expects_response,
  output logic [2:0]                            outcome,
  output logic [6:0]                            attempt_count,
  output logic [31:0]                           card_ocr,
  output logic [15:0]                           last_status,
  output logic                                  high_capacity,
  output logic [31:0]                           argument_in_use,
  // config write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sdinit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data
);
  import sdinit_pkg::*;

  cfg_t        cfg;
  result_t     result;
  logic        has_result;

  logic        s1_valid;
  logic        s1_opcode;
  logic [15:0] s1_status;
  logic [31:0] s1_resp;
  logic        s1_go;
  logic        out_free;

  sdinit_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sdinit_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .go            (s1_go),
    .opcode        (s1_opcode),
    .status_flags  (s1_status),
    .response_word (s1_resp),
    .cfg           (cfg),
    .has_result    (has_result),
    .result        (result)
  );

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!has_result || out_free);
  assign in_stall = s1_valid && !s1_go;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode <= opcode;
      s1_status <= status_flags;
      s1_resp   <= response_word;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && has_result) begin
      command_valid    <= result.command_valid;
      command_index    <= result.command_index;
      command_argument <= result.command_argument;
      expects_response <= result.expects_response;
      outcome          <= result.outcome;
      attempt_count    <= result.attempt_count;
      card_ocr         <= result.card_ocr;
      last_status      <= result.last_status;
      high_capacity    <= result.high_capacity;
      argument_in_use  <= result.argument_in_use;
    end
  end

endmodule

`default_nettype wire

### src/sdinit_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdinit_cfg_regs: configuration register bank
// Six registers written by index; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sdinit_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sdinit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                  cfg_data,
  output sdinit_pkg::cfg_t                  cfg
);
  import sdinit_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_attempts      <= RST_MAX_ATTEMPTS;
      cfg.hcs_drop_attempt  <= RST_HCS_DROP;
      cfg.start_argument    <= RST_START_ARG;
      cfg.feedback_mask     <= RST_FEEDBACK_MASK;
      cfg.fallback_argument <= RST_FALLBACK_ARG;
      cfg.check_pattern     <= RST_CHECK_PATTERN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_ATTEMPTS:  cfg.max_attempts      <= cfg_data[6:0];
        CFG_HCS_DROP:      cfg.hcs_drop_attempt  <= cfg_data[6:0];
        CFG_START_ARG:     cfg.start_argument    <= cfg_data;
        CFG_FEEDBACK_MASK: cfg.feedback_mask     <= cfg_data;
        CFG_FALLBACK_ARG:  cfg.fallback_argument <= cfg_data;
        CFG_CHECK_PATTERN: cfg.check_pattern     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/sdinit_seq.sv
// ----------------------------------------------------------------------------
// sdinit_seq: bring-up state machine
// Judges one request per cycle while go is high, updates sequence state and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sdinit_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic               opcode,
  input  wire logic [15:0]        status_flags,
  input  wire logic [31:0]        response_word,
  input  wire sdinit_pkg::cfg_t   cfg,
  output logic                    has_result,
  output sdinit_pkg::result_t     result
);
  import sdinit_pkg::*;

  phase_t      phase, phase_next;
  logic [6:0]  round_counter, round_counter_next;
  logic [31:0] acmd_argument, acmd_argument_next;
  logic        window_captured, window_captured_next;
  logic [31:0] saved_ocr, saved_ocr_next;

  logic        ok;
  logic        echo_ok;
  logic        take_window;
  logic [31:0] arg_fb;
  logic [6:0]  round_inc;
  logic        ocr_ready;

  assign ok          = (status_flags & ST_RECEIVED) != 16'd0;
  assign echo_ok     = response_word == {20'd0, cfg.check_pattern};
  assign take_window = !window_captured && ((response_word & OCR_WINDOW) != 32'd0);
  assign arg_fb      = take_window ? (response_word & cfg.feedback_mask) : acmd_argument;
  assign round_inc   = round_counter + 7'd1;
  assign ocr_ready   = response_word[OCR_READY_BIT];

  // next state
  always_comb begin
    phase_next           = phase;
    round_counter_next   = round_counter;
    acmd_argument_next   = acmd_argument;
    window_captured_next = window_captured;
    saved_ocr_next       = saved_ocr;
    if (opcode == OP_START) begin
      phase_next           = PH_CMD0;
      round_counter_next   = 7'd0;
      acmd_argument_next   = cfg.start_argument;
      window_captured_next = 1'b0;
      saved_ocr_next       = 32'd0;
    end else begin
      case (phase)
        PH_CMD0:  phase_next = PH_CMD8;
        PH_CMD8:  phase_next = (ok && echo_ok) ? PH_CMD55 : PH_DONE;
        PH_CMD55: phase_next = ok ? PH_ACMD41 : PH_DONE;
        PH_ACMD41: begin
          if (!ok) begin
            phase_next = PH_DONE;
          end else begin
            saved_ocr_next = response_word;
            if (take_window) window_captured_next = 1'b1;
            if (ocr_ready) begin
              acmd_argument_next = arg_fb;
              phase_next         = PH_DONE;
            end else begin
              acmd_argument_next = (round_counter == cfg.hcs_drop_attempt)
                                   ? cfg.fallback_argument : arg_fb;
              round_counter_next = round_inc;
              phase_next = (round_inc >= cfg.max_attempts) ? PH_DONE : PH_CMD55;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    logic [2:0]  oc;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic        hc;
    oc  = OUT_RUNNING;
    idx = CMD_GO_IDLE;
    arg = 32'd0;
    hc  = 1'b0;
    has_result = 1'b1;
    if (opcode != OP_START) begin
      case (phase)
        PH_CMD0: begin
          idx = CMD_SEND_IF;
          arg = {20'd0, cfg.check_pattern};
        end
        PH_CMD8: begin
          if (ok && echo_ok) idx = CMD_APP;
          else               oc  = OUT_CHECK_FAIL;
        end
        PH_CMD55: begin
          if (ok) begin
            idx = ACMD_SD_OP_COND;
            arg = acmd_argument;
          end else begin
            oc = OUT_CMD55_FAIL;
          end
        end
        PH_ACMD41: begin
          if (!ok) begin
            oc = OUT_ACMD41_FAIL;
          end else if (ocr_ready) begin
            oc = OUT_READY;
            hc = response_word[OCR_HCS_BIT];
          end else if (round_inc >= cfg.max_attempts) begin
            oc = OUT_TIMEOUT;
          end else begin
            idx = CMD_APP;
          end
        end
        default: has_result = 1'b0;
      endcase
    end
    result.command_valid    = oc == OUT_RUNNING;
    result.command_index    = (oc == OUT_RUNNING) ? idx : CMD_GO_IDLE;
    result.command_argument = (oc == OUT_RUNNING) ? arg : 32'd0;
    result.expects_response = (oc == OUT_RUNNING) && (opcode != OP_START);
    result.outcome          = oc;
    result.attempt_count    = round_counter_next;
    result.card_ocr         = saved_ocr_next;
    result.last_status      = (opcode == OP_START) ? 16'd0 : status_flags;
    result.high_capacity    = hc;
    result.argument_in_use  = acmd_argument_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      round_counter   <= 7'd0;
      acmd_argument   <= 32'd0;
      window_captured <= 1'b0;
      saved_ocr       <= 32'd0;
    end else if (go) begin
      phase           <= phase_next;
      round_counter   <= round_counter_next;
      acmd_argument   <= acmd_argument_next;
      window_captured <= window_captured_next;
      saved_ocr       <= saved_ocr_next;
    end
  end

endmodule

`default_nettype wire

### src/sdinit_checker.sv
// ----------------------------------------------------------------------------
// sdinit_checker: port-level checks for the init sequencer
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sdinit_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        command_valid,
  input wire logic [5:0]  command_index,
  input wire logic [31:0] command_argument,
  input wire logic        expects_response,
  input wire logic [2:0]  outcome,
  input wire logic        high_capacity
);
  import sdinit_pkg::*;

  // result channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a finished sequence issues no command
  a_final_no_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome != OUT_RUNNING) |->
      (!command_valid && command_index == CMD_GO_IDLE && command_argument == 32'd0
       && !expects_response))
    else $error("command fields set on final outcome");

  // only CMD0 goes without a response
  a_cmd_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && command_valid) |->
      ((command_index == CMD_GO_IDLE && !expects_response) ||
       (command_index == CMD_SEND_IF && expects_response) ||
       (command_index == CMD_APP && expects_response) ||
       (command_index == ACMD_SD_OP_COND && expects_response)))
    else $error("bad command index or response flag");

  // capacity is only reported with a ready card
  a_hc_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && high_capacity) |-> (outcome == OUT_READY))
    else $error("high capacity without ready outcome");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(outcome) && $stable(command_argument)))
    else $error("stalled result changed");

endmodule

bind sd_card_init_sequencer_core sdinit_checker u_sdinit_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .command_valid    (command_valid),
  .command_index    (command_index),
  .command_argument (command_argument),
  .expects_response (expects_response),
  .outcome          (outcome),
  .high_capacity    (high_capacity)
);

`default_nettype wire
